// ===== src/hkrb_pkg.sv =====
// Package for the HID keyboard report builder.
// Holds the operation codes, report sizes and the controller-to-datapath command type.
// Used by the controller, the datapath, the top level and the checker.
package hkrb_pkg;

  // Default number of working key slots and number of slots shown in a report.
  localparam int KEY_SLOTS_DEF = 6;
  localparam int OUT_SLOTS     = 6;

  // Operation codes carried in the func field.
  localparam logic [1:0] FUNC_ADD    = 2'd0;
  localparam logic [1:0] FUNC_REMOVE = 2'd1;
  localparam logic [1:0] FUNC_COMMIT = 2'd2;

  // Modifier usage codes 0xE0..0xE7 share the upper five bits.
  localparam logic [4:0] MOD_PREFIX = 5'b11100;
  localparam logic [7:0] MOD_FIRST  = 8'hE0;
  localparam logic [7:0] MOD_LAST   = 8'hE7;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic key_en;    // apply a key event this cycle
    logic is_add;    // key event is an add (else a remove)
    logic load_out;  // capture the working report into the output register
  } hkrb_cmd_t;

endpackage

// ===== src/hkrb_if.sv =====
// Valid/ready channel interfaces for the HID keyboard report builder.
// hkrb_in_if carries key events, hkrb_out_if carries finished reports.
// No dependencies.
interface hkrb_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] key_code;

  modport source (output valid, output func, output key_code, input ready);
  modport sink   (input valid, input func, input key_code, output ready);
endinterface

interface hkrb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] modifier_byte;
  logic [7:0] slot_0;
  logic [7:0] slot_1;
  logic [7:0] slot_2;
  logic [7:0] slot_3;
  logic [7:0] slot_4;
  logic [7:0] slot_5;

  modport source (output valid, output modifier_byte, output slot_0, output slot_1,
                  output slot_2, output slot_3, output slot_4, output slot_5,
                  input ready);
  modport sink   (input valid, input modifier_byte, input slot_0, input slot_1,
                  input slot_2, input slot_3, input slot_4, input slot_5,
                  output ready);
endinterface

// ===== src/hkrb_ctrl.sv =====
// Controller of the HID keyboard report builder: input handshake and output register state.
// Issues hkrb_cmd_t commands to the datapath.
// Depends on hkrb_pkg.
module hkrb_ctrl
  import hkrb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_func,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output hkrb_cmd_t  cmd
);

  typedef enum logic {
    ST_EMPTY,
    ST_FULL
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  // A new event is taken whenever the output register is empty or drains this cycle.
  assign in_ready  = (state_r == ST_EMPTY) || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = (state_r == ST_FULL);

  // Decode the accepted event into datapath commands.
  always_comb begin
    cmd.key_en   = accept && ((in_func == FUNC_ADD) || (in_func == FUNC_REMOVE));
    cmd.is_add   = (in_func == FUNC_ADD);
    cmd.load_out = accept && (in_func == FUNC_COMMIT);
  end

  // Output register occupancy.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_EMPTY: begin
        if (cmd.load_out) state_nxt = ST_FULL;
      end
      ST_FULL: begin
        if (cmd.load_out)    state_nxt = ST_FULL;
        else if (out_ready)  state_nxt = ST_EMPTY;
      end
      default: state_nxt = ST_EMPTY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_EMPTY;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== src/hkrb_datapath.sv =====
// Datapath of the HID keyboard report builder: modifier byte, sorted key slots, report register.
// All slots compare against the event code in parallel, so the working registers take an event at its transfer edge.
// Depends on hkrb_pkg.
module hkrb_datapath
  import hkrb_pkg::*;
#(
  parameter int KEY_SLOTS = KEY_SLOTS_DEF
)
(
  input  logic       clk,
  input  logic       rst_n,
  input  hkrb_cmd_t  cmd,
  input  logic [7:0] key_code,
  output logic [7:0] modifier_byte,
  output logic [7:0] out_slots [OUT_SLOTS]
);

  logic [7:0]           mods_r;
  logic [7:0]           mods_nxt;
  logic [7:0]           slots_r    [KEY_SLOTS];
  logic [7:0]           slots_nxt  [KEY_SLOTS];
  logic [7:0]           ins_val    [KEY_SLOTS];
  logic [7:0]           rem_val    [KEY_SLOTS];
  logic [7:0]           slot_prev  [KEY_SLOTS];
  logic [7:0]           slot_next  [KEY_SLOTS];
  logic [KEY_SLOTS-1:0] lt;
  logic [KEY_SLOTS-1:0] eq;
  logic [KEY_SLOTS-1:0] ins_prev;
  logic [KEY_SLOTS-1:0] del_from;
  logic [7:0]           mods_out_r;
  logic [7:0]           slots_out_r [OUT_SLOTS];
  logic [7:0]           report_slots [OUT_SLOTS];
  logic                 is_mod;
  logic                 code_nz;
  logic                 hit;
  logic                 add_ok;
  logic                 rem_ok;
  logic [7:0]           mod_bit;

  assign is_mod  = (key_code[7:3] == MOD_PREFIX);
  assign code_nz = (key_code != 8'd0);
  assign mod_bit = 8'd1 << key_code[2:0];
  assign hit     = |eq;

  // Per-slot compare and the shifted candidates for insert and delete.
  for (genvar g = 0; g < KEY_SLOTS; g++) begin : g_slot
    assign lt[g] = (slots_r[g] != 8'd0) && (slots_r[g] < key_code);
    assign eq[g] = (slots_r[g] == key_code);

    if (g == 0) begin : g_first
      assign ins_prev[g]  = 1'b1;
      assign slot_prev[g] = slots_r[g];
      assign del_from[g]  = eq[g];
    end else begin : g_rest
      assign ins_prev[g]  = lt[g-1];
      assign slot_prev[g] = slots_r[g-1];
      assign del_from[g]  = del_from[g-1] | eq[g];
    end

    if (g == KEY_SLOTS - 1) begin : g_last
      assign slot_next[g] = 8'd0;
    end else begin : g_inner
      assign slot_next[g] = slots_r[g+1];
    end

    // Insert: keep smaller codes, place the new code at the boundary, shift the rest up.
    assign ins_val[g] = lt[g] ? slots_r[g] : (ins_prev[g] ? key_code : slot_prev[g]);
    // Delete: from the matching slot onward, take the next slot's code.
    assign rem_val[g] = del_from[g] ? slot_next[g] : slots_r[g];
  end

  // An add of a nonzero non-modifier code needs a free last slot and no duplicate; a remove needs a match.
  assign add_ok = cmd.key_en && cmd.is_add && !is_mod && code_nz &&
                  (slots_r[KEY_SLOTS-1] == 8'd0) && !hit;
  assign rem_ok = cmd.key_en && !cmd.is_add && !is_mod && code_nz && hit;

  // Next working state.
  always_comb begin
    mods_nxt = mods_r;
    if (cmd.key_en && is_mod) begin
      if (cmd.is_add) mods_nxt = mods_r | mod_bit;
      else            mods_nxt = mods_r & ~mod_bit;
    end
    for (int i = 0; i < KEY_SLOTS; i++) begin
      if (add_ok)      slots_nxt[i] = ins_val[i];
      else if (rem_ok) slots_nxt[i] = rem_val[i];
      else             slots_nxt[i] = slots_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mods_r <= 8'd0;
      for (int i = 0; i < KEY_SLOTS; i++) slots_r[i] <= 8'd0;
    end else begin
      mods_r <= mods_nxt;
      for (int i = 0; i < KEY_SLOTS; i++) slots_r[i] <= slots_nxt[i];
    end
  end

  // Report view of the working slots; slots beyond the working set read as empty.
  for (genvar o = 0; o < OUT_SLOTS; o++) begin : g_out
    if (o < KEY_SLOTS) begin : g_kept
      assign report_slots[o] = slots_r[o];
    end else begin : g_pad
      assign report_slots[o] = 8'd0;
    end
  end

  // Report register, loaded on commit.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      mods_out_r <= mods_r;
      for (int o = 0; o < OUT_SLOTS; o++) slots_out_r[o] <= report_slots[o];
    end
  end

  assign modifier_byte = mods_out_r;
  assign out_slots     = slots_out_r;

endmodule

// ===== src/hid_keyboard_report_builder.sv =====
// HID boot keyboard report builder.
//
// Input channel in_ch carries key events (func, key_code): add, remove or commit.
// Modifier codes 0xE0..0xE7 set or clear one bit of the modifier byte; other
// nonzero codes are held in KEY_SLOTS slots kept in ascending order, zero-padded.
// Output channel out_ch carries one report (modifier_byte, slot_0..slot_5) per
// commit; add and remove events produce no transfer.
//
// For each event the slots compare against the code in parallel and the working
// report updates at the transfer edge. A commit's report shows on out_ch in the
// cycle after its input transfer. One event per cycle is taken as long as the
// output register is empty or being drained.
//
// Reset clears the modifier byte, empties all slots and marks the output register
// empty. When the receiver stalls with a report waiting, in_ch.ready drops until
// that report is taken; the waiting report holds steady meanwhile.
// Depends on hkrb_pkg, hkrb_if, hkrb_ctrl and hkrb_datapath.
module hid_keyboard_report_builder
  import hkrb_pkg::*;
#(
  parameter int KEY_SLOTS = KEY_SLOTS_DEF
)
(
  input  logic        clk,
  input  logic        rst_n,
  hkrb_in_if.sink     in_ch,
  hkrb_out_if.source  out_ch
);

  hkrb_cmd_t  cmd;
  logic [7:0] out_slots [OUT_SLOTS];

  // Handshake control.
  hkrb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_func   (in_ch.func),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  // Working report and output register.
  hkrb_datapath #(
    .KEY_SLOTS (KEY_SLOTS)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .key_code      (in_ch.key_code),
    .modifier_byte (out_ch.modifier_byte),
    .out_slots     (out_slots)
  );

  assign out_ch.slot_0 = out_slots[0];
  assign out_ch.slot_1 = out_slots[1];
  assign out_ch.slot_2 = out_slots[2];
  assign out_ch.slot_3 = out_slots[3];
  assign out_ch.slot_4 = out_slots[4];
  assign out_ch.slot_5 = out_slots[5];

endmodule

// ===== src/hkrb_checker.sv =====
// Port-level checks for the HID keyboard report builder, bound to the top level.
// Watches the event and report channels only.
// Depends on hkrb_pkg and hid_keyboard_report_builder.
module hkrb_checker
  import hkrb_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] in_func,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] slot_0,
  input logic [7:0] slot_1
);

  // A waiting report stays offered until it is transferred.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("report withdrawn before transfer");

  // A commit transfer always yields a report in the next cycle.
  a_commit_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_func == FUNC_COMMIT) |=> out_valid)
    else $error("commit did not produce a report");

  // The first two held codes come out in strictly ascending order with no gap.
  a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (slot_1 != 8'd0) |-> (slot_0 != 8'd0) && (slot_0 < slot_1))
    else $error("report slots out of order");

  // Modifier codes never land in key slot 0.
  a_no_mod_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (slot_0 < MOD_FIRST) || (slot_0 > MOD_LAST))
    else $error("modifier code found in a key slot");

endmodule

bind hid_keyboard_report_builder hkrb_checker u_hkrb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_func   (in_ch.func),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .slot_0    (out_ch.slot_0),
  .slot_1    (out_ch.slot_1)
);
